// ----- design/brlfd_pkg.sv -----
// shared types, constants and codes of the bilevel run-length frame decoder
package brlfd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	// register reset values
	localparam logic [7:0] PPL_RESET = 8'd240;
	localparam logic [7:0] LPF_RESET = 8'd180;

	// byte codes of the stream
	localparam logic [7:0] CMD_LITERAL = 8'h01;
	localparam logic [7:0] CMD_LONG    = 8'h02;
	localparam logic [7:0] EXIT_BLACK  = 8'h00;
	localparam logic [7:0] EXIT_WHITE  = 8'hFF;

	// header bookkeeping: seven bytes follow the first one, the second of these carries the colour
	localparam logic [2:0] HEADER_FIRST = 3'd7;
	localparam logic [2:0] HEADER_COLOR = 3'd6;

	// pixels in one literal byte
	localparam logic [3:0] LIT_PIXELS = 4'd8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PIXELS_PER_LINE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINES_PER_FRAME = 1'd1;

	typedef enum logic [1:0] {
		LONG_NONE = 2'd0,
		LONG_LOW  = 2'd1,
		LONG_HIGH = 2'd2
	} long_stage_t;

	typedef enum logic [3:0] {
		KIND_START,
		KIND_HEADER,
		KIND_IDLE,
		KIND_LIT_EXIT,
		KIND_LIT_PIX,
		KIND_LONG_LO,
		KIND_LIT_ENTER,
		KIND_LONG_ENTER,
		KIND_RUN
	} kind_t;

	typedef enum logic [1:0] {
		MOD_IDLE,
		MOD_BUSY,
		MOD_DONE
	} mod_state_t;

	typedef struct packed {
		logic             pixel_white;
		logic [LEN_W-1:0] run_length;
		logic             frame_done;
		logic             last;
	} result_t;

	typedef struct packed {
		logic             req;
		logic             clear;
		logic [LEN_W-1:0] dividend;
	} mod_req_t;

	typedef struct packed {
		logic        rdy;
		logic [7:0]  rem;
	} mod_rsp_t;

	typedef struct packed {
		logic emit;
		logic retire;
	} core_stat_t;

endpackage

// ----- design/brlfd_mod_unit.sv -----
// remainder of a 16-bit run position by the line width, two bits per cycle
module brlfd_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  brlfd_pkg::mod_req_t req,
	input  logic [7:0]          divisor,
	output brlfd_pkg::mod_rsp_t rsp
);

	brlfd_pkg::mod_state_t state_q, state_d;
	logic [2:0]  cnt_q;
	logic [15:0] dvd_q;
	logic [7:0]  rem_q;

	logic        fast;
	logic [7:0]  fast_rem;
	logic [8:0]  t1, t2;
	logic [7:0]  r1, r2;
	logic        load, step;

	// dividend below twice the divisor: one compare and subtract
	assign fast     = {1'b0, req.dividend} < {8'd0, divisor, 1'b0};
	assign fast_rem = (req.dividend >= {8'd0, divisor}) ?
		8'(req.dividend - {8'd0, divisor}) : req.dividend[7:0];

	assign t1 = {rem_q, dvd_q[15]};
	assign r1 = (t1 >= {1'b0, divisor}) ? 8'(t1 - {1'b0, divisor}) : t1[7:0];
	assign t2 = {r1, dvd_q[14]};
	assign r2 = (t2 >= {1'b0, divisor}) ? 8'(t2 - {1'b0, divisor}) : t2[7:0];

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		case (state_q)
			brlfd_pkg::MOD_IDLE: begin
				if (req.req && !fast) begin
					load    = 1'b1;
					state_d = brlfd_pkg::MOD_BUSY;
				end
			end
			brlfd_pkg::MOD_BUSY: begin
				step = 1'b1;
				if (cnt_q == 3'd7) begin
					state_d = brlfd_pkg::MOD_DONE;
				end
			end
			brlfd_pkg::MOD_DONE: begin
				state_d = brlfd_pkg::MOD_DONE;
			end
			default: begin
				state_d = brlfd_pkg::MOD_IDLE;
			end
		endcase
		if (req.clear) begin
			state_d = brlfd_pkg::MOD_IDLE;
			load    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brlfd_pkg::MOD_IDLE;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= 3'd0;
			end else if (step) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= req.dividend;
			rem_q <= 8'd0;
		end else if (step) begin
			dvd_q <= {dvd_q[13:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign rsp.rdy = fast || (state_q == brlfd_pkg::MOD_DONE);
	assign rsp.rem = fast ? fast_rem : rem_q;

	a_done_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == brlfd_pkg::MOD_DONE |-> rem_q < divisor)
		else $error("remainder not below divisor");

	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == brlfd_pkg::MOD_BUSY && cnt_q == 3'd7 |=> state_q == brlfd_pkg::MOD_DONE)
		else $error("division did not finish after eight steps");

endmodule

// ----- design/brlfd_out_reg.sv -----
// result register between the decoder and the output channel
module brlfd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  brlfd_pkg::result_t data,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               free,
	output brlfd_pkg::result_t result
);

	logic               valid_q;
	brlfd_pkg::result_t data_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= data;
		end
	end

	assign out_valid = valid_q;
	assign result    = data_q;

endmodule

// ----- design/brlfd_decode.sv -----
// byte decoder: stream state, run and literal result generation
module brlfd_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [7:0]            byte_s1,
	input  logic                  start_s1,
	input  logic [7:0]            ppl,
	input  logic [7:0]            lpf,
	input  logic                  out_free,
	input  brlfd_pkg::mod_rsp_t   mod_rsp,
	output brlfd_pkg::mod_req_t   mod_req,
	output brlfd_pkg::core_stat_t stat,
	output brlfd_pkg::result_t    res
);

	// stream state
	logic [15:0]            pixels_left_q;
	logic [7:0]             column_left_q;
	logic                   literal_mode_q;
	logic                   color_now_q;
	logic                   color_line_q;
	logic [2:0]             header_index_q;
	brlfd_pkg::long_stage_t long_stage_q;
	logic [7:0]             long_low_q;
	logic [2:0]             emit_idx_q;

	logic [15:0]            pixels_left_d;
	logic [7:0]             column_left_d;
	logic                   literal_mode_d;
	logic                   color_now_d;
	logic                   color_line_d;
	logic [2:0]             header_index_d;
	brlfd_pkg::long_stage_t long_stage_d;
	logic [7:0]             long_low_d;
	logic [2:0]             emit_idx_d;

	brlfd_pkg::kind_t kind;

	// run path
	logic [15:0] run_count, run_n, run_after, c16;
	logic        cl_eff, run_split, run_done, run_short, need_mod;
	logic [7:0]  run_col;

	// literal path
	logic [3:0]  lit_m, lit_len, lit_end;
	logic        lit_bit, lit_on, lit_last, lit_cl;
	logic [7:0]  lit_col;

	logic has_res, mod_ok, emit, retire;

	always_comb begin
		kind = brlfd_pkg::KIND_RUN;
		if (start_s1) begin
			kind = brlfd_pkg::KIND_START;
		end else if (header_index_q != 3'd0) begin
			kind = brlfd_pkg::KIND_HEADER;
		end else if (pixels_left_q == 16'd0) begin
			kind = brlfd_pkg::KIND_IDLE;
		end else if (literal_mode_q) begin
			if (byte_s1 == brlfd_pkg::EXIT_BLACK || byte_s1 == brlfd_pkg::EXIT_WHITE) begin
				kind = brlfd_pkg::KIND_LIT_EXIT;
			end else begin
				kind = brlfd_pkg::KIND_LIT_PIX;
			end
		end else begin
			case (long_stage_q)
				brlfd_pkg::LONG_LOW:  kind = brlfd_pkg::KIND_LONG_LO;
				brlfd_pkg::LONG_HIGH: kind = brlfd_pkg::KIND_RUN;
				default: begin
					if (byte_s1 == brlfd_pkg::CMD_LITERAL) begin
						kind = brlfd_pkg::KIND_LIT_ENTER;
					end else if (byte_s1 == brlfd_pkg::CMD_LONG) begin
						kind = brlfd_pkg::KIND_LONG_ENTER;
					end else begin
						kind = brlfd_pkg::KIND_RUN;
					end
				end
			endcase
		end
	end

	// run mode: length clipped at frame end, split where it crosses into a line
	// that starts with the other colour
	assign run_count = (long_stage_q == brlfd_pkg::LONG_HIGH) ?
		{byte_s1, long_low_q} : {8'd0, byte_s1};
	assign run_n     = (run_count < pixels_left_q) ? run_count : pixels_left_q;
	assign c16       = {8'd0, column_left_q};
	assign cl_eff    = (column_left_q == 8'd0) ? color_now_q : color_line_q;
	assign run_split = (column_left_q != 8'd0) && (run_n > c16) && (cl_eff != color_now_q);
	assign run_after = pixels_left_q - run_n;
	assign run_done  = (run_after == 16'd0);
	assign run_short = (column_left_q != 8'd0) && (run_n < c16);
	assign need_mod  = (kind == brlfd_pkg::KIND_RUN) && (run_n != 16'd0) && !run_short
		&& (ppl != 8'd0);

	assign mod_req.req      = valid_s1 && need_mod;
	assign mod_req.dividend = (column_left_q == 8'd0) ? run_n : run_n - c16;
	assign mod_req.clear    = retire;

	always_comb begin
		if (run_n == 16'd0) begin
			run_col = column_left_q;
		end else if (run_short) begin
			run_col = column_left_q - run_n[7:0];
		end else if (ppl == 8'd0 || mod_rsp.rem == 8'd0) begin
			run_col = 8'd0;
		end else begin
			run_col = ppl - mod_rsp.rem;
		end
	end

	// literal mode: pixels of this byte, and the stretch of equal ones from the
	// current emit position
	assign lit_m   = (pixels_left_q >= 16'd8) ? brlfd_pkg::LIT_PIXELS : pixels_left_q[3:0];
	assign lit_bit = byte_s1[3'(3'd7 - emit_idx_q)];

	always_comb begin
		lit_len = 4'd0;
		lit_on  = 1'b1;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) >= {1'b0, emit_idx_q} && 4'(j) < lit_m) begin
				if (lit_on && byte_s1[3'(7 - j)] == lit_bit) begin
					lit_len = lit_len + 4'd1;
				end else begin
					lit_on = 1'b0;
				end
			end
		end
	end

	assign lit_end  = {1'b0, emit_idx_q} + lit_len;
	assign lit_last = (lit_end == lit_m);

	// column and line colour after the literal pixels, one pixel a step
	always_comb begin
		lit_col = column_left_q;
		lit_cl  = color_line_q;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < lit_m) begin
				if (lit_col == 8'd0) begin
					lit_cl  = byte_s1[3'(7 - i)];
					lit_col = (ppl == 8'd0) ? 8'd0 : ppl - 8'd1;
				end else begin
					lit_col = lit_col - 8'd1;
				end
			end
		end
	end

	// result for the current emit position
	always_comb begin
		has_res = 1'b0;
		res     = '0;
		if (kind == brlfd_pkg::KIND_RUN) begin
			has_res = (run_n != 16'd0);
			if (emit_idx_q == 3'd0) begin
				res.pixel_white = color_now_q;
				res.run_length  = run_split ? c16 : run_n;
				res.frame_done  = run_split ? 1'b0 : run_done;
				res.last        = !run_split;
			end else begin
				res.pixel_white = cl_eff;
				res.run_length  = run_n - c16;
				res.frame_done  = run_done;
				res.last        = 1'b1;
			end
		end else if (kind == brlfd_pkg::KIND_LIT_PIX) begin
			has_res         = 1'b1;
			res.pixel_white = lit_bit;
			res.run_length  = {12'd0, lit_len};
			res.frame_done  = lit_last && (pixels_left_q == {12'd0, lit_m});
			res.last        = lit_last;
		end
	end

	assign mod_ok = !need_mod || mod_rsp.rdy;
	assign emit   = valid_s1 && has_res && mod_ok && out_free;
	assign retire = valid_s1 && mod_ok && (!has_res || (emit && res.last));

	assign stat.emit   = emit;
	assign stat.retire = retire;

	// state after the item
	always_comb begin
		pixels_left_d  = pixels_left_q;
		column_left_d  = column_left_q;
		literal_mode_d = literal_mode_q;
		color_now_d    = color_now_q;
		color_line_d   = color_line_q;
		header_index_d = header_index_q;
		long_stage_d   = long_stage_q;
		long_low_d     = long_low_q;
		case (kind)
			brlfd_pkg::KIND_START: begin
				pixels_left_d  = {8'd0, ppl} * {8'd0, lpf};
				column_left_d  = 8'd0;
				literal_mode_d = 1'b0;
				color_now_d    = 1'b0;
				color_line_d   = 1'b0;
				header_index_d = brlfd_pkg::HEADER_FIRST;
				long_stage_d   = brlfd_pkg::LONG_NONE;
				long_low_d     = 8'd0;
			end
			brlfd_pkg::KIND_HEADER: begin
				if (header_index_q == brlfd_pkg::HEADER_COLOR) begin
					color_now_d  = (byte_s1 != 8'd0);
					color_line_d = (byte_s1 != 8'd0);
				end
				header_index_d = header_index_q - 3'd1;
			end
			brlfd_pkg::KIND_LIT_EXIT: begin
				literal_mode_d = 1'b0;
				color_now_d    = (byte_s1 == brlfd_pkg::EXIT_WHITE);
				if (column_left_q < 8'd8) begin
					color_line_d = (byte_s1 == brlfd_pkg::EXIT_WHITE);
				end
			end
			brlfd_pkg::KIND_LIT_PIX: begin
				pixels_left_d = pixels_left_q - {12'd0, lit_m};
				column_left_d = lit_col;
				color_line_d  = lit_cl;
				color_now_d   = 1'b0;
			end
			brlfd_pkg::KIND_LONG_LO: begin
				long_low_d   = byte_s1;
				long_stage_d = brlfd_pkg::LONG_HIGH;
			end
			brlfd_pkg::KIND_LIT_ENTER: begin
				literal_mode_d = 1'b1;
			end
			brlfd_pkg::KIND_LONG_ENTER: begin
				long_stage_d = brlfd_pkg::LONG_LOW;
			end
			brlfd_pkg::KIND_RUN: begin
				long_stage_d  = brlfd_pkg::LONG_NONE;
				color_line_d  = cl_eff;
				pixels_left_d = run_after;
				column_left_d = run_col;
				color_now_d   = ((column_left_q != 8'd0 && run_n >= c16) ? cl_eff : color_now_q)
					^ 1'b1;
			end
			default: begin
				pixels_left_d = pixels_left_q;
			end
		endcase
	end

	always_comb begin
		emit_idx_d = emit_idx_q;
		if (retire) begin
			emit_idx_d = 3'd0;
		end else if (emit) begin
			emit_idx_d = (kind == brlfd_pkg::KIND_RUN) ? 3'd1 : lit_end[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q  <= 16'd0;
			column_left_q  <= 8'd0;
			literal_mode_q <= 1'b0;
			color_now_q    <= 1'b0;
			color_line_q   <= 1'b0;
			header_index_q <= 3'd0;
			long_stage_q   <= brlfd_pkg::LONG_NONE;
			long_low_q     <= 8'd0;
			emit_idx_q     <= 3'd0;
		end else begin
			emit_idx_q <= emit_idx_d;
			if (retire) begin
				pixels_left_q  <= pixels_left_d;
				column_left_q  <= column_left_d;
				literal_mode_q <= literal_mode_d;
				color_now_q    <= color_now_d;
				color_line_q   <= color_line_d;
				header_index_q <= header_index_d;
				long_stage_q   <= long_stage_d;
				long_low_q     <= long_low_d;
			end
		end
	end

	a_idx_clear_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> emit_idx_q == 3'd0)
		else $error("emit position left over with no item held");

	a_run_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind == brlfd_pkg::KIND_RUN |-> emit_idx_q <= 3'd1)
		else $error("run byte past its second result");

endmodule

// ----- design/bilevel_run_length_frame_decoder_unit.sv -----
// top level of the bilevel run-length frame decoder
//
// channels
//   in_valid / in_ready: one encoded byte per item, frame_start marking the
//   first header byte of a frame; out_valid / out_ready: one colour run per
//   item, last set on the final run caused by an input byte, frame_done on the
//   run ending the frame; cfg_write / cfg_index / cfg_data write pixels_per_line
//   and lines_per_frame, which the user must do only while the block is idle; it is not enforced
// data flow
//   an accepted byte sits in the input register; its runs are loaded into the
//   result register; one result leaves per cycle while out_ready is high and
//   no remainder is awaited; a run byte gives up to two results, a literal
//   byte up to eight; a run whose pixels from its first line start on reach two
//   or more line widths waits on the remainder unit (one load, eight steps of
//   two bits each)
// reset and stalls
//   arst_n clears all stream state (no frame active, run mode, width 240,
//   180 lines) and holds in_ready low; while out_ready is low the result
//   register holds, and the next byte is still taken when the held one has
//   no results or has handed its last one over
module bilevel_run_length_frame_decoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_write,
	input  logic [brlfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [brlfd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// byte input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [brlfd_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                  frame_start,
	// run output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  pixel_white,
	output logic [brlfd_pkg::LEN_W-1:0]           run_length,
	output logic                                  frame_done,
	output logic                                  last
);

	// configuration registers
	logic [7:0] ppl_q;
	logic [7:0] lpf_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	brlfd_pkg::core_stat_t stat;
	brlfd_pkg::result_t    res;
	brlfd_pkg::result_t    out_res;
	brlfd_pkg::mod_req_t   mod_req;
	brlfd_pkg::mod_rsp_t   mod_rsp;
	logic                  out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q <= brlfd_pkg::PPL_RESET;
			lpf_q <= brlfd_pkg::LPF_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				brlfd_pkg::REG_PIXELS_PER_LINE: ppl_q <= cfg_data;
				brlfd_pkg::REG_LINES_PER_FRAME: lpf_q <= cfg_data;
				default: begin
					ppl_q <= ppl_q;
				end
			endcase
		end
	end

	// a new byte enters when the register is empty or its item retires now
	assign in_ready = arst_n && (!valid_s1 || stat.retire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
		end
	end

	// decoder: stream state and result selection
	brlfd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1),
		.ppl      (ppl_q),
		.lpf      (lpf_q),
		.out_free (out_free),
		.mod_rsp  (mod_rsp),
		.mod_req  (mod_req),
		.stat     (stat),
		.res      (res)
	);

	// column remainder for runs that wrap over line starts
	brlfd_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mod_req),
		.divisor (ppl_q),
		.rsp     (mod_rsp)
	);

	// result register towards the receiver
	brlfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (stat.emit),
		.data      (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.result    (out_res)
	);

	assign pixel_white = out_res.pixel_white;
	assign run_length  = out_res.run_length;
	assign frame_done  = out_res.frame_done;
	assign last        = out_res.last;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last)
		else $error("frame end reported on a run that is not the last of its item");

endmodule
